// ===== design/fpl_pkg.sv =====
// ----------------------------------------------------------------------------
// fpl_pkg
// Shared types, constants and the control store of the four-pole ladder core.
// ----------------------------------------------------------------------------
package fpl_pkg;

  // Datapath widths
  localparam int STAGE_W    = 32;              // ladder stage value
  localparam int D_W        = 36;              // multiplier signed operand
  localparam int B_W        = 19;              // multiplier gain operand (zero-extended)
  localparam int P_W        = D_W + B_W;       // full product
  localparam int ALU_W      = 40;              // adder width
  localparam int Q_FRAC     = 16;              // fraction bits of the gains
  localparam int NUM_STAGES = 4;
  localparam int K_W        = 2;               // stage index in the loop
  localparam int PC_W       = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int COEF_W     = 17;
  localparam int RES_W      = 18;
  localparam int GAIN_W     = 17;

  typedef enum logic [1:0] {
    MODE_LP,
    MODE_HP,
    MODE_BP,
    MODE_ZERO
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LADDER_COEF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESONANCE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_GAIN    = 3'd4;

  localparam mode_t               RST_MODE = MODE_HP;
  localparam logic [COEF_W-1:0]   RST_COEF = 17'd8173;
  localparam logic [RES_W-1:0]    RST_RES  = 18'd32768;
  localparam logic [GAIN_W-1:0]   RST_OG   = 17'd49152;
  localparam logic [GAIN_W-1:0]   RST_DG   = 17'd0;

  typedef struct packed {
    mode_t             mode;
    logic [COEF_W-1:0] coef;
    logic [RES_W-1:0]  res;
    logic [GAIN_W-1:0] out_gain;
    logic [GAIN_W-1:0] dry_gain;
  } cfg_t;

  // Control word fields
  typedef enum logic [1:0] {
    MA_D,
    MA_X,
    MA_S4
  } mul_a_t;

  typedef enum logic [1:0] {
    MB_RES,
    MB_COEF,
    MB_OG,
    MB_DG
  } mul_b_t;

  typedef enum logic [2:0] {
    ALU_NONE,   // no write
    ALU_FB,     // d = x - round(prod)
    ALU_SUB0,   // d = d - stage one
    ALU_UPD,    // stage k = clamp32(stage k + round(prod))
    ALU_DIFF,   // d = stage k - stage k+1, advance k
    ALU_FILT,   // d = mode selection
    ALU_HOLD,   // acc = round(prod)
    ALU_OUT     // result = sat(acc + round(prod)), write stages back
  } alu_op_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_ALWAYS,
    J_LAST
  } jmp_t;

  typedef struct packed {
    logic            mul_en;
    mul_a_t          mul_a;
    mul_b_t          mul_b;
    alu_op_t         alu;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    ucode_t         uc;
    logic [K_W-1:0] k;
    logic           start;
    logic           adv;
  } dp_ctrl_t;

  // Program addresses
  localparam logic [PC_W-1:0] ST_FB_MUL    = 4'd0;
  localparam logic [PC_W-1:0] ST_FB_SUM    = 4'd1;
  localparam logic [PC_W-1:0] ST_DIFF0     = 4'd2;
  localparam logic [PC_W-1:0] ST_LOOP_MUL  = 4'd3;
  localparam logic [PC_W-1:0] ST_LOOP_UPD  = 4'd4;
  localparam logic [PC_W-1:0] ST_LOOP_DIFF = 4'd5;
  localparam logic [PC_W-1:0] ST_FILT      = 4'd6;
  localparam logic [PC_W-1:0] ST_GAIN_MUL  = 4'd7;
  localparam logic [PC_W-1:0] ST_DRY_MUL   = 4'd8;
  localparam logic [PC_W-1:0] ST_OUT       = 4'd9;

  // Control store: one word per step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uc;
    uc = '{mul_en: 1'b0, mul_a: MA_D, mul_b: MB_COEF, alu: ALU_NONE,
           jmp: J_NEXT, target: ST_FB_MUL};
    unique case (pc)
      ST_FB_MUL: begin
        uc.mul_en = 1'b1;
        uc.mul_a  = MA_S4;
        uc.mul_b  = MB_RES;
      end
      ST_FB_SUM: begin
        uc.alu = ALU_FB;
      end
      ST_DIFF0: begin
        uc.alu = ALU_SUB0;
      end
      ST_LOOP_MUL: begin
        uc.mul_en = 1'b1;
        uc.mul_a  = MA_D;
        uc.mul_b  = MB_COEF;
      end
      ST_LOOP_UPD: begin
        uc.alu    = ALU_UPD;
        uc.jmp    = J_LAST;
        uc.target = ST_FILT;
      end
      ST_LOOP_DIFF: begin
        uc.alu    = ALU_DIFF;
        uc.jmp    = J_ALWAYS;
        uc.target = ST_LOOP_MUL;
      end
      ST_FILT: begin
        uc.alu = ALU_FILT;
      end
      ST_GAIN_MUL: begin
        uc.mul_en = 1'b1;
        uc.mul_a  = MA_D;
        uc.mul_b  = MB_OG;
      end
      ST_DRY_MUL: begin
        uc.alu    = ALU_HOLD;
        uc.mul_en = 1'b1;
        uc.mul_a  = MA_X;
        uc.mul_b  = MB_DG;
      end
      ST_OUT: begin
        uc.alu    = ALU_OUT;
        uc.jmp    = J_ALWAYS;
        uc.target = ST_FB_MUL;
      end
      default: begin
        uc.jmp    = J_ALWAYS;
        uc.target = ST_FB_MUL;
      end
    endcase
    return uc;
  endfunction

endpackage

// ===== design/fpl_datapath.sv =====
// ----------------------------------------------------------------------------
// fpl_datapath
// Shared multiplier, adder/clamp unit and per-channel ladder stage storage.
// ----------------------------------------------------------------------------
module fpl_datapath #(
  parameter int NUM_CHANNELS = 2,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fpl_pkg::dp_ctrl_t              ctrl,
  input  fpl_pkg::cfg_t                  cfg,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  logic                           channel_index,
  output logic signed [SAMPLE_WIDTH-1:0] y_sat
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ALU_W   = fpl_pkg::ALU_W;
  localparam int STAGE_W = fpl_pkg::STAGE_W;
  localparam int D_W     = fpl_pkg::D_W;
  localparam int B_W     = fpl_pkg::B_W;
  localparam int P_W     = fpl_pkg::P_W;
  localparam int NSTG    = fpl_pkg::NUM_STAGES;

  localparam logic signed [P_W-1:0]   RND_HALF = P_W'(1) <<< (fpl_pkg::Q_FRAC - 1);
  localparam logic signed [ALU_W-1:0] ST_MAX =
    ALU_W'((64'sd1 <<< (STAGE_W - 1)) - 64'sd1);
  localparam logic signed [ALU_W-1:0] ST_MIN = -ST_MAX - ALU_W'(1);
  localparam logic signed [ALU_W-1:0] SMP_MAX =
    ALU_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ALU_W-1:0] SMP_MIN = -SMP_MAX - ALU_W'(1);

  logic signed [STAGE_W-1:0]      stage_mem_r [NUM_CHANNELS][NSTG];
  logic signed [STAGE_W-1:0]      w_r [NSTG];
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic [CH_W-1:0]                ch_r;
  logic signed [D_W-1:0]          d_r;
  logic signed [P_W-1:0]          prod_r;
  logic signed [ALU_W-1:0]        acc_r;

  logic [CH_W-1:0]                ch_idx;
  logic signed [D_W-1:0]          opa;
  logic signed [B_W-1:0]          opb;
  logic signed [P_W-1:0]          prod_nxt;
  logic signed [P_W-1:0]          p_rnd;
  logic signed [ALU_W-1:0]        r;
  logic signed [ALU_W-1:0]        x_a;
  logic signed [ALU_W-1:0]        d_a;
  logic signed [ALU_W-1:0]        wk_a;
  logic signed [ALU_W-1:0]        wk1_a;
  logic signed [ALU_W-1:0]        w3_a;
  logic signed [ALU_W-1:0]        filt;
  logic signed [ALU_W-1:0]        upd_sum;
  logic signed [STAGE_W-1:0]      w_upd_nxt;
  logic signed [ALU_W-1:0]        d_sum;
  logic signed [D_W-1:0]          d_nxt;
  logic signed [ALU_W-1:0]        y_sum;
  logic [fpl_pkg::K_W-1:0]        k_up;

  // Wrap the channel onto the stored channels
  assign ch_idx = CH_W'((NUM_CHANNELS > 1) ? channel_index : 1'b0);

  // Select multiplier operands
  always_comb begin
    case (ctrl.uc.mul_a)
      fpl_pkg::MA_X:  opa = D_W'(x_r);
      fpl_pkg::MA_S4: opa = D_W'(w_r[NSTG-1]);
      default:        opa = d_r;
    endcase
    case (ctrl.uc.mul_b)
      fpl_pkg::MB_RES:  opb = B_W'(cfg.res);
      fpl_pkg::MB_COEF: opb = B_W'(cfg.coef);
      fpl_pkg::MB_OG:   opb = B_W'(cfg.out_gain);
      default:          opb = B_W'(cfg.dry_gain);
    endcase
    prod_nxt = opa * opb;
  end

  // Round the last product half up to an integer
  always_comb begin
    p_rnd = prod_r + RND_HALF;
    r     = ALU_W'(p_rnd >>> fpl_pkg::Q_FRAC);
  end

  // Adder, stage clamp and mode selection
  always_comb begin
    k_up  = ctrl.k + 2'd1;
    x_a   = ALU_W'(x_r);
    d_a   = ALU_W'(d_r);
    wk_a  = ALU_W'(w_r[ctrl.k]);
    wk1_a = ALU_W'(w_r[k_up]);
    w3_a  = ALU_W'(w_r[NSTG-1]);

    upd_sum = wk_a + r;
    if (upd_sum > ST_MAX) begin
      w_upd_nxt = STAGE_W'(ST_MAX);
    end else if (upd_sum < ST_MIN) begin
      w_upd_nxt = STAGE_W'(ST_MIN);
    end else begin
      w_upd_nxt = STAGE_W'(upd_sum);
    end

    case (cfg.mode)
      fpl_pkg::MODE_LP: filt = w3_a;
      fpl_pkg::MODE_HP: filt = x_a - w3_a;
      fpl_pkg::MODE_BP: filt = x_a - (w3_a <<< 1);
      default:          filt = '0;
    endcase

    case (ctrl.uc.alu)
      fpl_pkg::ALU_FB:   d_sum = x_a - r;
      fpl_pkg::ALU_SUB0: d_sum = d_a - ALU_W'(w_r[0]);
      fpl_pkg::ALU_DIFF: d_sum = wk_a - wk1_a;
      fpl_pkg::ALU_FILT: d_sum = filt;
      default:           d_sum = d_a;
    endcase
    d_nxt = D_W'(d_sum);

    y_sum = acc_r + r;
    if (y_sum > SMP_MAX) begin
      y_sat = SAMPLE_WIDTH'(SMP_MAX);
    end else if (y_sum < SMP_MIN) begin
      y_sat = SAMPLE_WIDTH'(SMP_MIN);
    end else begin
      y_sat = SAMPLE_WIDTH'(y_sum);
    end
  end

  // Hold the per-channel stages; write back when the result leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        for (int s = 0; s < NSTG; s++) begin
          stage_mem_r[c][s] <= '0;
        end
      end
    end else if (ctrl.adv && ctrl.uc.alu == fpl_pkg::ALU_OUT) begin
      for (int s = 0; s < NSTG; s++) begin
        stage_mem_r[ch_r][s] <= w_r[s];
      end
    end
  end

  // Load the working set on a new request, then run the program
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      x_r  <= sample_in;
      ch_r <= ch_idx;
      for (int s = 0; s < NSTG; s++) begin
        w_r[s] <= stage_mem_r[ch_idx][s];
      end
    end else if (ctrl.adv) begin
      if (ctrl.uc.mul_en) begin
        prod_r <= prod_nxt;
      end
      case (ctrl.uc.alu) inside
        fpl_pkg::ALU_FB, fpl_pkg::ALU_SUB0, fpl_pkg::ALU_DIFF, fpl_pkg::ALU_FILT: begin
          d_r <= d_nxt;
        end
        fpl_pkg::ALU_UPD: begin
          w_r[ctrl.k] <= w_upd_nxt;
        end
        fpl_pkg::ALU_HOLD: begin
          acc_r <= r;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/four_pole_ladder_filter_core.sv =====
// Requests are taken one at a time: the input closes on an accept and reopens
// after the last program step; the single shared multiplier and the ten-word
// program (four-pass stage loop) carry each request through step by step.
// A result waiting at the output holds the last program step until taken.
// Reset (rst_n low, synchronous) zeroes all ladder stages, loads the register
// defaults and empties the output.
// ----------------------------------------------------------------------------
// four_pole_ladder_filter_core
// Resonant four-pole ladder filter with mode select and dry mix, run by a
// small microcoded sequencer over one multiplier and one adder.
// ----------------------------------------------------------------------------
module four_pole_ladder_filter_core #(
  parameter int NUM_CHANNELS = 2,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample_in,
  input  logic                                in_channel_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      out_sample_out,
  input  logic                                cfg_wr_en,
  input  logic [fpl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fpl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  fpl_pkg::cfg_t                  cfg_r;
  logic                           busy_r;
  logic                           busy_nxt;
  logic [fpl_pkg::PC_W-1:0]       pc_r;
  logic [fpl_pkg::PC_W-1:0]       pc_nxt;
  logic [fpl_pkg::K_W-1:0]        k_r;
  logic [fpl_pkg::K_W-1:0]        k_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;

  fpl_pkg::ucode_t                cw;
  fpl_pkg::dp_ctrl_t              dp_ctrl;
  logic                           start;
  logic                           stall;
  logic                           adv;
  logic                           done;
  logic                           last;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= fpl_pkg::RST_MODE;
      cfg_r.coef     <= fpl_pkg::RST_COEF;
      cfg_r.res      <= fpl_pkg::RST_RES;
      cfg_r.out_gain <= fpl_pkg::RST_OG;
      cfg_r.dry_gain <= fpl_pkg::RST_DG;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        fpl_pkg::REG_FILTER_MODE: cfg_r.mode     <= fpl_pkg::mode_t'(cfg_wdata[1:0]);
        fpl_pkg::REG_LADDER_COEF: cfg_r.coef     <= cfg_wdata[fpl_pkg::COEF_W-1:0];
        fpl_pkg::REG_RESONANCE:   cfg_r.res      <= cfg_wdata[fpl_pkg::RES_W-1:0];
        fpl_pkg::REG_OUTPUT_GAIN: cfg_r.out_gain <= cfg_wdata[fpl_pkg::GAIN_W-1:0];
        fpl_pkg::REG_DRY_GAIN:    cfg_r.dry_gain <= cfg_wdata[fpl_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Fetch the control word and decide whether the program advances
  always_comb begin
    cw    = fpl_pkg::ucode_rom(pc_r);
    start = in_valid && !busy_r;
    stall = busy_r && cw.alu == fpl_pkg::ALU_OUT && out_valid_r && !out_ready;
    adv   = busy_r && !stall;
    done  = adv && cw.alu == fpl_pkg::ALU_OUT;
    last  = (k_r == fpl_pkg::K_W'(fpl_pkg::NUM_STAGES - 1));
  end

  // Step counter, loop index and busy flag
  always_comb begin
    pc_nxt   = pc_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    if (start) begin
      pc_nxt   = fpl_pkg::ST_FB_MUL;
      k_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (adv) begin
      case (cw.jmp)
        fpl_pkg::J_ALWAYS: pc_nxt = cw.target;
        fpl_pkg::J_LAST:   pc_nxt = last ? cw.target : pc_r + 1'b1;
        default:           pc_nxt = pc_r + 1'b1;
      endcase
      if (cw.alu == fpl_pkg::ALU_DIFF) begin
        k_nxt = k_r + 1'b1;
      end
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Output register: load on the last step, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= fpl_pkg::ST_FB_MUL;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_sample_r <= y_sat;
    end
  end

  assign dp_ctrl = '{uc: cw, k: k_r, start: start, adv: adv};

  fpl_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (dp_ctrl),
    .cfg           (cfg_r),
    .sample_in     (in_sample_in),
    .channel_index (in_channel_index),
    .y_sat         (y_sat)
  );

  assign in_ready       = !busy_r;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

// ===== design/fpl_checker.sv =====
// ----------------------------------------------------------------------------
// fpl_checker
// Port-level checks of the ladder core, attached to every instance by bind.
// ----------------------------------------------------------------------------
module fpl_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [SAMPLE_WIDTH-1:0]      out_sample_out
);

  // Reset empties the output and opens the input
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("core not idle after reset");

  // One request at a time: the input closes after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while busy");

  // A result never appears the cycle right after an accept, and the input
  // reopens as it appears
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready && !$past(in_valid && in_ready))
    else $error("result timing broken");

  // A waiting result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_sample_out))
    else $error("stalled result changed");

endmodule

bind four_pole_ladder_filter_core fpl_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_fpl_checker (.*);
